>>> rtl/core/dnu_pkg.sv
// Package for the deal number unranker: shared types, constants and controller codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dnu_pkg;
  localparam int HandCount = 4;
  localparam int MaxHand = 13;
  localparam int IndexBits = 96;
  localparam int KBits = 128;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MULT,
    ST_MULT_WAIT,
    ST_DIV_WAIT,
    ST_RANGE,
    ST_CARD_START,
    ST_HAND_SUB,
    ST_HAND_WAIT,
    ST_HAND_CMP,
    ST_EMIT,
    ST_ERROR
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_INIT,
    CMD_MUL_START,
    CMD_DIV_START,
    CMD_K_TAKE,
    CMD_CARD_INIT,
    CMD_HAND_SUB,
    CMD_HAND_MUL,
    CMD_HAND_DIV,
    CMD_PICK,
    CMD_NEXT_HAND,
    CMD_NEXT_CARD
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic       bad_cap;
    logic       idx_ge_k;
    logic       idx_lt_x;
    logic       mult_done;
    logic       cap_zero;
    logic       last_hand;
    logic       unit_done;
    logic       cards_zero;
    logic       card_last;
  } status_t;
endpackage
`default_nettype wire

>>> rtl/core/dnu_datapath.sv
// Datapath: index, K, capacities, card counter and a shared serial mul/div unit.
// Uses dnu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dnu_datapath #(
  parameter int HAND_COUNT = dnu_pkg::HandCount,
  parameter int MAX_HAND = dnu_pkg::MaxHand,
  parameter int INDEX_BITS = dnu_pkg::IndexBits
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire dnu_pkg::cmd_t cmd,
  input  wire logic [63:0] index_low,
  input  wire logic [31:0] index_high,
  input  wire logic [3:0] free_hand0,
  input  wire logic [3:0] free_hand1,
  input  wire logic [3:0] free_hand2,
  input  wire logic [3:0] free_hand3,
  output dnu_pkg::status_t status,
  output logic [5:0] card_value,
  output logic [1:0] hand_value
);
  localparam int KW = dnu_pkg::KBits;
  localparam int CW = 6;

  logic [KW-1:0] idx, k, x, acc, quo;
  logic [3:0] cap [4];
  logic [5:0] total, cnum, mcount;
  logic [1:0] hsel;
  logic [3:0] jcnt;
  logic [5:0] opnd;
  logic [7:0] bit_cnt;
  logic unit_busy, unit_mul, unit_done;
  logic [CW:0] rem;
  logic [KW-1:0] mcand;
  logic [KW-1:0] in_idx;
  logic [3:0] in_cap [4];
  logic [7:0] caps_sum;
  logic bad_cap;
  logic [CW:0] rem_shift;

  always_comb begin
    in_idx = {32'd0, index_high, index_low};
    if (INDEX_BITS < KW) in_idx = in_idx & ((KW'(1) << INDEX_BITS) - KW'(1));
    in_cap[0] = free_hand0;
    in_cap[1] = free_hand1;
    in_cap[2] = (HAND_COUNT > 2) ? free_hand2 : 4'd0;
    in_cap[3] = (HAND_COUNT > 3) ? free_hand3 : 4'd0;
    bad_cap = 1'b0;
    caps_sum = '0;
    for (int i = 0; i < 4; i++) begin
      if (cap[i] > 4'(MAX_HAND)) bad_cap = 1'b1;
      caps_sum = caps_sum + 8'(in_cap[i]);
    end
  end

  // shift-add multiply by 6-bit operand, restoring divide by 6-bit divisor
  always_comb rem_shift = {rem[CW-1:0], quo[KW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_busy <= 1'b0;
      unit_done <= 1'b0;
    end else begin
      unit_done <= 1'b0;
      if (cmd == dnu_pkg::CMD_MUL_START || cmd == dnu_pkg::CMD_HAND_MUL) begin
        unit_busy <= 1'b1;
        unit_mul <= 1'b1;
        bit_cnt <= 8'd6;
        acc <= '0;
        mcand <= (cmd == dnu_pkg::CMD_MUL_START) ? k : k;
        opnd <= (cmd == dnu_pkg::CMD_MUL_START) ? mcount + 6'd1 : 6'(cap[hsel]);
      end else if (cmd == dnu_pkg::CMD_DIV_START || cmd == dnu_pkg::CMD_HAND_DIV) begin
        unit_busy <= 1'b1;
        unit_mul <= 1'b0;
        bit_cnt <= 8'(KW);
        quo <= acc;
        rem <= '0;
        opnd <= (cmd == dnu_pkg::CMD_DIV_START) ? 6'(jcnt) : cnum;
      end else if (unit_busy) begin
        if (unit_mul) begin
          if (opnd[0]) acc <= acc + mcand;
          mcand <= mcand << 1;
          opnd <= opnd >> 1;
        end else begin
          if (rem_shift >= {1'b0, opnd}) begin
            rem <= rem_shift - {1'b0, opnd};
            quo <= {quo[KW-2:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[KW-2:0], 1'b0};
          end
        end
        bit_cnt <= bit_cnt - 8'd1;
        if (bit_cnt == 8'd1) begin
          unit_busy <= 1'b0;
          unit_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      k <= '0;
      x <= '0;
      for (int i = 0; i < 4; i++) cap[i] <= '0;
      total <= '0;
      cnum <= '0;
      mcount <= '0;
      hsel <= '0;
      jcnt <= '0;
    end else begin
      case (cmd)
        dnu_pkg::CMD_LOAD: begin
          idx <= in_idx;
          for (int i = 0; i < 4; i++) cap[i] <= in_cap[i];
          total <= caps_sum[5:0];
          k <= KW'(1);
        end
        dnu_pkg::CMD_MUL_INIT: begin
          mcount <= '0;
          hsel <= '0;
          jcnt <= 4'd1;
        end
        dnu_pkg::CMD_MUL_START: mcount <= mcount + 6'd1;
        dnu_pkg::CMD_K_TAKE: begin
          // advance the factor; the hand is left once jcnt passes its capacity
          k <= quo;
          jcnt <= jcnt + 4'd1;
        end
        dnu_pkg::CMD_NEXT_HAND: begin
          if (jcnt >= cap[hsel] || cap[hsel] == 4'd0) begin
            jcnt <= 4'd1;
            hsel <= hsel + 2'd1;
          end
        end
        dnu_pkg::CMD_CARD_INIT: begin
          cnum <= total;
          x <= '0;
          hsel <= '0;
        end
        dnu_pkg::CMD_HAND_SUB: idx <= idx - x;
        dnu_pkg::CMD_PICK: begin
          if (cap[hsel] != 4'd0) cap[hsel] <= cap[hsel] - 4'd1;
          k <= quo;
          x <= '0;
        end
        dnu_pkg::CMD_HAND_DIV: ;
        dnu_pkg::CMD_NEXT_CARD: begin
          x <= quo;
          hsel <= hsel + 2'd1;
        end
        default: ;
      endcase
      if (cmd == dnu_pkg::CMD_NEXT_CARD) ;
      if (cmd == dnu_pkg::CMD_PICK) begin
        cnum <= cnum - 6'd1;
        hsel <= '0;
      end
    end
  end

  always_comb begin
    status.busy = unit_busy;
    status.unit_done = unit_done;
    status.bad_cap = bad_cap;
    status.idx_ge_k = !(idx < k);
    status.idx_lt_x = idx < quo;
    status.mult_done = (32'(hsel) >= HAND_COUNT - 1) &&
                       (cap[hsel] == 4'd0 || jcnt > cap[hsel]);
    status.cap_zero = cap[hsel] == 4'd0 || jcnt > cap[hsel];
    status.last_hand = 32'(hsel) == HAND_COUNT - 1;
    status.cards_zero = cnum == 6'd0;
    status.card_last = cnum == 6'd1;
    card_value = total - cnum;
    hand_value = hsel;
  end
endmodule
`default_nettype wire

>>> rtl/core/dnu_controller.sv
// Controller state machine sequencing multinomial build, range check and card walk.
// Uses dnu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dnu_controller (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  output logic out_last,
  output logic out_bad,
  input  wire dnu_pkg::status_t status,
  output dnu_pkg::cmd_t cmd
);
  dnu_pkg::state_t state, state_next;
  logic first_hand, first_hand_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dnu_pkg::ST_IDLE;
      first_hand <= 1'b0;
    end else begin
      state <= state_next;
      first_hand <= first_hand_next;
    end
  end

  always_comb begin
    state_next = state;
    first_hand_next = first_hand;
    cmd = dnu_pkg::CMD_NONE;
    in_stall = 1'b1;
    out_valid = 1'b0;
    out_last = 1'b0;
    out_bad = 1'b0;
    case (state)
      dnu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd = dnu_pkg::CMD_LOAD;
          state_next = dnu_pkg::ST_CHECK;
        end
      end
      dnu_pkg::ST_CHECK: begin
        cmd = dnu_pkg::CMD_MUL_INIT;
        state_next = status.bad_cap ? dnu_pkg::ST_ERROR : dnu_pkg::ST_MULT;
      end
      dnu_pkg::ST_MULT: begin
        // skip hands whose factors are exhausted
        if (status.mult_done) begin
          state_next = dnu_pkg::ST_RANGE;
        end else if (status.cap_zero) begin
          cmd = dnu_pkg::CMD_NEXT_HAND;
        end else begin
          cmd = dnu_pkg::CMD_MUL_START;
          state_next = dnu_pkg::ST_MULT_WAIT;
        end
      end
      dnu_pkg::ST_MULT_WAIT: begin
        if (status.unit_done) begin
          cmd = dnu_pkg::CMD_DIV_START;
          state_next = dnu_pkg::ST_DIV_WAIT;
        end
      end
      dnu_pkg::ST_DIV_WAIT: begin
        if (status.unit_done) begin
          cmd = dnu_pkg::CMD_K_TAKE;
          state_next = dnu_pkg::ST_MULT;
        end
      end
      dnu_pkg::ST_RANGE: begin
        if (status.idx_ge_k) begin
          state_next = dnu_pkg::ST_ERROR;
        end else begin
          cmd = dnu_pkg::CMD_CARD_INIT;
          state_next = dnu_pkg::ST_CARD_START;
        end
      end
      dnu_pkg::ST_CARD_START: begin
        if (status.cards_zero) begin
          state_next = dnu_pkg::ST_IDLE;
        end else begin
          state_next = dnu_pkg::ST_HAND_SUB;
        end
      end
      dnu_pkg::ST_HAND_SUB: begin
        cmd = dnu_pkg::CMD_HAND_SUB;
        first_hand_next = 1'b1;
        state_next = dnu_pkg::ST_HAND_WAIT;
      end
      dnu_pkg::ST_HAND_WAIT: begin
        if (first_hand) begin
          cmd = dnu_pkg::CMD_HAND_MUL;
          first_hand_next = 1'b0;
        end else if (status.unit_done && !status.busy) begin
          cmd = dnu_pkg::CMD_HAND_DIV;
          state_next = dnu_pkg::ST_HAND_CMP;
        end
      end
      dnu_pkg::ST_HAND_CMP: begin
        if (status.unit_done) begin
          if (status.idx_lt_x || status.last_hand) begin
            state_next = dnu_pkg::ST_EMIT;
          end else begin
            cmd = dnu_pkg::CMD_NEXT_CARD;
            state_next = dnu_pkg::ST_HAND_SUB;
          end
        end
      end
      dnu_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        out_last = status.card_last;
        if (!out_stall) begin
          cmd = dnu_pkg::CMD_PICK;
          state_next = dnu_pkg::ST_CARD_START;
        end
      end
      dnu_pkg::ST_ERROR: begin
        out_valid = 1'b1;
        out_last = 1'b1;
        out_bad = 1'b1;
        if (!out_stall) state_next = dnu_pkg::ST_IDLE;
      end
      default: state_next = dnu_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_in_only_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == dnu_pkg::ST_IDLE) else $error("input taken while busy");
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    out_bad |-> out_last) else $error("error result not last");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

>>> rtl/core/deal_number_unranker_unit.sv
// Deal number unranker (top level): sequential multinomial unranking.
// Each multiply and divide pair runs on the shared serial unit; the build needs
// one pair per card, the walk up to four.
// One request at a time; input stalled until the last result is taken.
// Synchronous active-high reset returns to idle and clears working state.
`timescale 1ns / 1ps
`default_nettype none
module deal_number_unranker_unit #(
  parameter int HAND_COUNT = dnu_pkg::HandCount,
  parameter int MAX_HAND = dnu_pkg::MaxHand,
  parameter int INDEX_BITS = dnu_pkg::IndexBits
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [63:0] index_low,
  input  wire logic [31:0] index_high,
  input  wire logic [3:0] free_hand0,
  input  wire logic [3:0] free_hand1,
  input  wire logic [3:0] free_hand2,
  input  wire logic [3:0] free_hand3,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [5:0] card_ordinal,
  output logic [1:0] hand_number,
  output logic last_card,
  output logic bad_request
);
  dnu_pkg::cmd_t cmd;
  dnu_pkg::status_t status;
  logic [5:0] card_value;
  logic [1:0] hand_value;
  logic out_bad;

  dnu_datapath #(.HAND_COUNT(HAND_COUNT), .MAX_HAND(MAX_HAND),
    .INDEX_BITS(INDEX_BITS)) u_dp (
    .clk, .rst, .cmd, .index_low, .index_high, .free_hand0, .free_hand1,
    .free_hand2, .free_hand3, .status, .card_value, .hand_value);

  dnu_controller u_ctl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_last(last_card), .out_bad, .status, .cmd);

  assign bad_request = out_bad;
  assign card_ordinal = out_bad ? 6'd0 : card_value;
  assign hand_number = out_bad ? 2'd0 : hand_value;
endmodule
`default_nettype wire

>>> verif/deal_number_checker.sv
// Checker for the deal number unranker: watches the request and result channels, predicts
// the card-to-hand results of each accepted request and compares them in order.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module deal_number_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] index_low,
  input  logic [31:0] index_high,
  input  logic [3:0]  free_hand0,
  input  logic [3:0]  free_hand1,
  input  logic [3:0]  free_hand2,
  input  logic [3:0]  free_hand3,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  card_ordinal,
  input  logic [1:0]  hand_number,
  input  logic        last_card,
  input  logic        bad_request,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [5:0] ordinal;
    logic [1:0] hand;
    logic       last;
    logic       bad;
  } card_deal_t;

  card_deal_t dealt_cards[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Work out every card result of one request.
  task automatic unrank_deal(input logic [95:0] deal_no, input logic [3:0] room [4]);
    logic [127:0] idx;
    logic [127:0] k;
    logic [127:0] x;
    logic [3:0]   cap [4];
    int           total;
    int           m;
    int           pick;
    bit           bad;
    bit           found;
    card_deal_t   r;
    idx = {32'b0, deal_no};
    total = 0;
    m = 0;
    bad = 0;
    k = 128'd1;
    for (int i = 0; i < 4; i++) begin
      cap[i] = room[i];
      if (cap[i] > 13) bad = 1;
      total += cap[i];
    end
    if (!bad) begin
      for (int i = 0; i < 4; i++)
        for (int j = 1; j <= cap[i]; j++) begin
          m++;
          k = (k * m) / j;
        end
      if (idx >= k) bad = 1;
    end
    if (bad) begin
      r = '{ordinal: 6'd0, hand: 2'd0, last: 1'b1, bad: 1'b1};
      dealt_cards.push_back(r);
    end else begin
      for (int c = total; c > 0; c--) begin
        x = '0;
        pick = 0;
        found = 0;
        for (int i = 0; i < 4; i++) begin
          if (!found) begin
            idx = idx - x;
            x = (k * cap[i]) / c;
            pick = i;
            if (idx < x) found = 1;
          end
        end
        if (cap[pick] > 0) cap[pick]--;
        k = x;
        r = '{ordinal: 6'(total - c), hand: 2'(pick), last: (c == 1), bad: 1'b0};
        dealt_cards.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    logic [3:0] room [4];
    card_deal_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        room[0] = free_hand0;
        room[1] = free_hand1;
        room[2] = free_hand2;
        room[3] = free_hand3;
        unrank_deal({index_high, index_low}, room);
      end
      if (out_valid && !out_stall) begin
        if (dealt_cards.size() == 0) begin
          report("unexpected result, ordinal", card_ordinal, -1);
        end else begin
          want = dealt_cards.pop_front();
          if (card_ordinal !== want.ordinal) report("card_ordinal", card_ordinal, want.ordinal);
          if (hand_number !== want.hand) report("hand_number", hand_number, want.hand);
          if (last_card !== want.last) report("last_card", last_card, want.last);
          if (bad_request !== want.bad) report("bad_request", bad_request, want.bad);
        end
      end
      pending = dealt_cards.size();
    end
  end
endmodule

>>> verif/tb.sv
// Testbench top for the deal number unranker: clock, reset, request stimulus
// with random idling and back pressure, and the verdict.
// Depends on dnu_pkg, deal_number_unranker_unit and deal_number_checker.
`timescale 1ns / 1ps
module tb;
  localparam int CycleLimit = 20000000;
  localparam int HoldCycles = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] index_low = '0;
  logic [31:0] index_high = '0;
  logic [3:0]  free_hand0 = '0;
  logic [3:0]  free_hand1 = '0;
  logic [3:0]  free_hand2 = '0;
  logic [3:0]  free_hand3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  card_ordinal;
  logic [1:0]  hand_number;
  logic        last_card;
  logic        bad_request;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          idling = 1'b1;
  int          hold_tag = 0;

  deal_number_unranker_unit dut (
    .clk, .rst, .in_valid, .in_stall, .index_low, .index_high,
    .free_hand0, .free_hand1, .free_hand2, .free_hand3,
    .out_valid, .out_stall, .card_ordinal, .hand_number, .last_card, .bad_request
  );

  deal_number_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .index_low, .index_high,
    .free_hand0, .free_hand1, .free_hand2, .free_hand3,
    .out_valid, .out_stall, .card_ordinal, .hand_number, .last_card, .bad_request,
    .fail_count, .pending
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  always @(negedge clk) begin
    int hold_left;
    int hold_seen;
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idling && ($urandom_range(99) < 25);
    end
  end

  // Number of possible deals, used to aim indexes at the valid range.
  function automatic logic [127:0] deal_space(input logic [3:0] h0, h1, h2, h3);
    logic [127:0] k;
    logic [3:0]   caps [4];
    int           m;
    caps = '{h0, h1, h2, h3};
    k = 128'd1;
    m = 0;
    for (int i = 0; i < 4; i++)
      for (int j = 1; j <= caps[i]; j++) begin
        m++;
        k = (k * m) / j;
      end
    return k;
  endfunction

  // Offer one request at the falling edge and hold it until accepted.
  task automatic send(input logic [95:0] deal_no, input logic [3:0] h0, h1, h2, h3);
    if (idling && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    {index_high, index_low} <= deal_no;
    free_hand0 <= h0;
    free_hand1 <= h1;
    free_hand2 <= h2;
    free_hand3 <= h3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [95:0] random_index();
    return {$urandom, $urandom, $urandom};
  endfunction

  task automatic send_valid(input logic [3:0] h0, h1, h2, h3);
    logic [127:0] k;
    k = deal_space(h0, h1, h2, h3);
    send(96'({32'b0, random_index()} % k), h0, h1, h2, h3);
  endtask

  initial begin
    logic [127:0] full;
    logic [3:0]   h [4];
    full = deal_space(4'd13, 4'd13, 4'd13, 4'd13);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty request, single cards, extremes, capacity and range errors.
    send('0, 4'd0, 4'd0, 4'd0, 4'd0);
    send('0, 4'd1, 4'd0, 4'd0, 4'd0);
    send('0, 4'd0, 4'd0, 4'd0, 4'd1);
    send(96'd1, 4'd0, 4'd0, 4'd0, 4'd1);
    send(96'd2, 4'd1, 4'd1, 4'd0, 4'd1);
    send(96'd5, 4'd1, 4'd1, 4'd1, 4'd0);
    send('0, 4'd13, 4'd13, 4'd13, 4'd13);
    send(96'(full - 1), 4'd13, 4'd13, 4'd13, 4'd13);
    send(96'(full), 4'd13, 4'd13, 4'd13, 4'd13);
    send('1, 4'd13, 4'd13, 4'd13, 4'd13);
    send('0, 4'd14, 4'd0, 4'd0, 4'd0);
    send('0, 4'd0, 4'd15, 4'd0, 4'd0);
    send('0, 4'd1, 4'd1, 4'd14, 4'd1);
    send('0, 4'd0, 4'd0, 4'd0, 4'd15);
    send('0, 4'd15, 4'd15, 4'd15, 4'd15);
    send(96'd6, 4'd2, 4'd2, 4'd0, 4'd0);
    send(96'd20, 4'd0, 4'd3, 4'd0, 4'd3);
    send(96'd3, 4'd0, 4'd2, 4'd2, 4'd0);

    for (int n = 0; n < 100; n++) begin
      idling = !(n >= 40 && n < 60);
      if (n == 25) hold_tag++;
      if (n == 70) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 5) begin
          send_valid(4'd13, 4'd13, 4'd13, 4'd13);
        end else begin
          for (int i = 0; i < 4; i++) h[i] = 4'($urandom_range(0, 3));
          if ($urandom_range(99) < 10) h[$urandom_range(3)] = 4'($urandom_range(4, 13));
          send_valid(h[0], h[1], h[2], h[3]);
        end
      end else begin
        send(random_index(), 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
      end
    end
    in_valid <= 1'b0;
    idling = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
